@@ design/kmeans_2d_point_clustering_defines.svh @@
// assertion macros for the 2-d k-means clustering block
// used by the top level, expects clk_i and rst_ni in scope
`ifndef KMEANS_2D_POINT_CLUSTERING_DEFINES_SVH
`define KMEANS_2D_POINT_CLUSTERING_DEFINES_SVH

// condition holds at every edge out of reset
`define KMC_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("kmc assertion failed");

// consequent in the same cycle
`define KMC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kmc assertion failed");

// consequent in the next cycle
`define KMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kmc assertion failed");

`endif

@@ design/kmc_pkg.sv @@
// shared types, constants and the distance function of the k-means block
// no dependencies
package kmc_pkg;

  localparam int unsigned XW = 9;
  localparam int unsigned YW = 8;
  localparam int unsigned DIST_W = 18;
  localparam int unsigned THR_W = 9;
  localparam int unsigned ITER_W = 8;
  localparam int unsigned NUMC_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned TDATA_W = 24;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TUSER_W = 3;
  localparam int unsigned IDX_OUT_W = 2;

  localparam int unsigned DEF_MAX_POINTS = 131072;
  localparam int unsigned DEF_MAX_CLUSTERS = 4;

  localparam logic [NUMC_W-1:0] RST_NUM_CLUSTERS = 3'd3;
  localparam logic [THR_W-1:0] RST_THRESHOLD = 9'd30;
  localparam logic [ITER_W-1:0] RST_MAX_ITER = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CLUSTERS = 2'd0,
    CFG_THRESHOLD    = 2'd1,
    CFG_MAX_ITER     = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } point_t;

  function automatic logic [DIST_W-1:0] sq_dist(point_t a, point_t b);
    logic signed [XW:0] dx;
    logic signed [YW:0] dy;
    logic signed [2*XW+1:0] dx2;
    logic signed [2*YW+1:0] dy2;
    dx = $signed({1'b0, a.x}) - $signed({1'b0, b.x});
    dy = $signed({1'b0, a.y}) - $signed({1'b0, b.y});
    dx2 = dx * dx;
    dy2 = dy * dy;
    return DIST_W'($unsigned(dx2)) + DIST_W'($unsigned(dy2));
  endfunction

endpackage

@@ design/kmc_pstore.sv @@
// point store: one write port, one read port with registered read data
// uses kmc_pkg
module kmc_pstore #(
  parameter int unsigned DEPTH = kmc_pkg::DEF_MAX_POINTS,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  kmc_pkg::point_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output kmc_pkg::point_t rdata_o
);
  import kmc_pkg::*;

  point_t mem [DEPTH];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/kmc_div.sv @@
// restoring divider, one quotient bit per cycle
// no dependencies
module kmc_div #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o
);
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0] quot_q, quot_d;
  logic [DW:0] rem_q, rem_d, rem_sh;
  logic [DW-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;

  always_comb begin
    rem_sh = {rem_q[DW-1:0], quot_q[NW-1]};
    quot_d = quot_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quot_d = {quot_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quot_d = {quot_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

@@ design/kmeans_2d_point_clustering.sv @@
// top level of the 2-d k-means point clustering block
// uses kmc_pkg, kmc_pstore, kmc_div and the assertion macro header
//
// usage:
//  s_axis: one word per foreground pixel, tdata = {pos_y, pos_x}, tuser = has_point,
//   tlast = frame end. points are taken one per cycle while loading; a point past
//   MAX_POINTS is dropped. the frame-end word starts clustering and s_axis_tready
//   stays low until the centres have been handed to the output register.
//  clustering: warm start from the kept centres, then passes over the point store.
//   each pass sweeps the store (one store read, k distance steps, one accumulate per
//   point) through the single store read port, then runs the per-centre divides on
//   the shared per-centre divider pair. passes run until converged or the cap.
//  m_axis: k words, tdata = {center_y, center_x}, tuser = {converged, index},
//   tlast on the last centre. one output register; a stalled receiver holds the
//   word and the sequencer waits. loading of the next frame may start while the
//   last word still waits.
//  cfg: index/data write port, always ready; written only while idle is a user rule, not enforced.
//  reset: centres and kept centres go to (0,0), point count to zero, registers
//   to 3 clusters, threshold 30, 64 passes. no clearing pass is needed.
`include "kmeans_2d_point_clustering_defines.svh"

module kmeans_2d_point_clustering #(
  parameter int unsigned MAX_POINTS = kmc_pkg::DEF_MAX_POINTS,
  parameter int unsigned MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [8:0] pos_x, [16:9] pos_y, [23:17] zero
  input  logic [kmc_pkg::TDATA_W-1:0]    s_axis_tdata,
  input  logic                           s_axis_tlast,
  // [0] has_point
  input  logic [kmc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [8:0] center_x, [16:9] center_y, [23:17] zero
  output logic [kmc_pkg::TDATA_W-1:0]    m_axis_tdata,
  output logic                           m_axis_tlast,
  // [1:0] cluster_index, [2] converged
  output logic [kmc_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kmc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned TW = $clog2(MAX_POINTS + 1);
  localparam int unsigned NCW = $clog2(MAX_POINTS + 2);
  localparam int unsigned SXW = XW + TW;
  localparam int unsigned SYW = YW + TW;
  localparam int unsigned CIW = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned CAW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_CLEAR, ST_READ, ST_DIST, ST_ACC,
    ST_UPD_START, ST_UPD_WAIT, ST_UPD_CMP, ST_PASS_END, ST_EMIT
  } state_e;

  state_e st_q;
  logic [NUMC_W-1:0] cfg_num_q;
  logic [THR_W-1:0] cfg_thr_q;
  logic [ITER_W-1:0] cfg_iter_q;

  point_t cent_q [MAX_CLUSTERS];
  point_t prior_q [MAX_CLUSTERS];
  logic [SXW-1:0] sumx_q [MAX_CLUSTERS];
  logic [SYW-1:0] sumy_q [MAX_CLUSTERS];
  logic [NCW-1:0] cnt_q [MAX_CLUSTERS];

  logic [TW-1:0] total_q, p_q;
  logic [CIW-1:0] c_q;
  logic [CAW-1:0] best_q;
  logic [DIST_W-1:0] bestd_q;
  logic [ITER_W-1:0] pass_q;
  logic [2*THR_W+1:0] thr_sq_q;
  logic conv_q;
  point_t nc_q;

  logic m_valid_q;
  logic [IDX_OUT_W-1:0] out_idx_q;
  point_t out_pt_q;
  logic out_conv_q, out_last_q;

  logic [3:0] num_ext;
  logic [CIW-1:0] k_w, klast_w;
  logic [ITER_W-1:0] cap_w, pass_inc;
  logic [CAW-1:0] c_idx;
  logic [THR_W:0] thr_p1;
  logic s_fire, we, re;
  point_t in_pt, rd_pt;
  logic [DIST_W-1:0] dist_w, move_w;
  logic div_start, busy_x, busy_y;
  logic [SXW-1:0] quot_x;
  logic [SYW-1:0] quot_y;
  logic out_free;

  assign num_ext = {1'b0, cfg_num_q};
  always_comb begin
    if (num_ext == 4'd0) begin
      k_w = CIW'(1);
    end else if (num_ext > 4'(MAX_CLUSTERS)) begin
      k_w = CIW'(MAX_CLUSTERS);
    end else begin
      k_w = CIW'(num_ext);
    end
  end
  assign klast_w = k_w - CIW'(1);
  assign cap_w = (cfg_iter_q == '0) ? ITER_W'(1) : cfg_iter_q;
  assign pass_inc = pass_q + ITER_W'(1);
  assign c_idx = c_q[CAW-1:0];
  assign thr_p1 = {1'b0, cfg_thr_q} + (THR_W+1)'(1);

  assign s_axis_tready = (st_q == ST_LOAD);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign in_pt.x = s_axis_tdata[XW-1:0];
  assign in_pt.y = s_axis_tdata[XW+YW-1:XW];
  assign we = s_fire && s_axis_tuser[0] && (total_q < TW'(MAX_POINTS));
  assign re = (st_q == ST_READ);

  kmc_pstore #(.DEPTH(MAX_POINTS), .AW(AW)) u_pstore (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (total_q[AW-1:0]),
    .wdata_i (in_pt),
    .re_i    (re),
    .raddr_i (p_q[AW-1:0]),
    .rdata_o (rd_pt)
  );

  assign div_start = (st_q == ST_UPD_START);

  kmc_div #(.NW(SXW), .DW(NCW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sumx_q[c_idx]),
    .divisor_i  (cnt_q[c_idx]),
    .busy_o     (busy_x),
    .quot_o     (quot_x)
  );

  kmc_div #(.NW(SYW), .DW(NCW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sumy_q[c_idx]),
    .divisor_i  (cnt_q[c_idx]),
    .busy_o     (busy_y),
    .quot_o     (quot_y)
  );

  assign dist_w = sq_dist(rd_pt, cent_q[c_idx]);
  assign move_w = sq_dist(nc_q, cent_q[c_idx]);
  assign out_free = !m_valid_q || m_axis_tready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD;
      cfg_num_q <= RST_NUM_CLUSTERS;
      cfg_thr_q <= RST_THRESHOLD;
      cfg_iter_q <= RST_MAX_ITER;
      total_q <= '0;
      p_q <= '0;
      c_q <= '0;
      pass_q <= '0;
      conv_q <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cent_q[i] <= '0;
        prior_q[i] <= '0;
        sumx_q[i] <= '0;
        sumy_q[i] <= '0;
        cnt_q[i] <= NCW'(1);
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_NUM_CLUSTERS: cfg_num_q <= cfg_data_i[NUMC_W-1:0];
          CFG_THRESHOLD:    cfg_thr_q <= cfg_data_i[THR_W-1:0];
          CFG_MAX_ITER:     cfg_iter_q <= cfg_data_i[ITER_W-1:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && st_q != ST_EMIT) begin
        m_valid_q <= 1'b0;
      end
      case (st_q)
        ST_LOAD: begin
          if (we) begin
            total_q <= total_q + TW'(1);
          end
          if (s_fire && s_axis_tlast) begin
            st_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          for (int i = 0; i < MAX_CLUSTERS; i++) begin
            if (CIW'(i) < k_w) begin
              cent_q[i] <= prior_q[i];
            end
          end
          pass_q <= '0;
          thr_sq_q <= (2*THR_W+2)'(thr_p1) * (2*THR_W+2)'(thr_p1);
          st_q <= ST_CLEAR;
        end
        ST_CLEAR: begin
          for (int i = 0; i < MAX_CLUSTERS; i++) begin
            sumx_q[i] <= '0;
            sumy_q[i] <= '0;
            cnt_q[i] <= NCW'(1);
          end
          conv_q <= 1'b1;
          p_q <= '0;
          c_q <= '0;
          st_q <= (total_q == '0) ? ST_UPD_START : ST_READ;
        end
        ST_READ: begin
          c_q <= '0;
          st_q <= ST_DIST;
        end
        ST_DIST: begin
          if (c_q == '0 || dist_w < bestd_q) begin
            bestd_q <= dist_w;
            best_q <= c_idx;
          end
          if (c_q == klast_w) begin
            st_q <= ST_ACC;
          end else begin
            c_q <= c_q + CIW'(1);
          end
        end
        ST_ACC: begin
          sumx_q[best_q] <= sumx_q[best_q] + SXW'(rd_pt.x);
          sumy_q[best_q] <= sumy_q[best_q] + SYW'(rd_pt.y);
          cnt_q[best_q] <= cnt_q[best_q] + NCW'(1);
          p_q <= p_q + TW'(1);
          c_q <= '0;
          st_q <= (p_q + TW'(1) == total_q) ? ST_UPD_START : ST_READ;
        end
        ST_UPD_START: begin
          st_q <= ST_UPD_WAIT;
        end
        ST_UPD_WAIT: begin
          if (!busy_x && !busy_y) begin
            nc_q.x <= quot_x[XW-1:0];
            nc_q.y <= quot_y[YW-1:0];
            st_q <= ST_UPD_CMP;
          end
        end
        ST_UPD_CMP: begin
          if ((2*THR_W+2)'(move_w) >= thr_sq_q) begin
            conv_q <= 1'b0;
          end
          prior_q[c_idx] <= cent_q[c_idx];
          cent_q[c_idx] <= nc_q;
          if (c_q == klast_w) begin
            st_q <= ST_PASS_END;
          end else begin
            c_q <= c_q + CIW'(1);
            st_q <= ST_UPD_START;
          end
        end
        ST_PASS_END: begin
          pass_q <= pass_inc;
          c_q <= '0;
          if (conv_q || pass_inc >= cap_w) begin
            total_q <= '0;
            st_q <= ST_EMIT;
          end else begin
            st_q <= ST_CLEAR;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            out_idx_q <= IDX_OUT_W'(c_q);
            out_pt_q <= cent_q[c_idx];
            out_conv_q <= conv_q;
            out_last_q <= (c_q == klast_w);
            if (c_q == klast_w) begin
              st_q <= ST_LOAD;
            end else begin
              c_q <= c_q + CIW'(1);
            end
          end
        end
        default: st_q <= ST_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = TDATA_W'({out_pt_q.y, out_pt_q.x});
  assign m_axis_tlast = out_last_q;
  assign m_axis_tuser = {out_conv_q, out_idx_q};

  `KMC_ASSERT_HOLDS(a_total_bound, total_q <= TW'(MAX_POINTS))
  `KMC_ASSERT_NEXT(a_frame_end_starts, s_axis_tvalid && s_axis_tready && s_axis_tlast, st_q == ST_INIT)
  `KMC_ASSERT_IMPL(a_div_idle_on_cmp, st_q == ST_UPD_CMP, !busy_x && !busy_y)
  `KMC_ASSERT_NEXT(a_emit_on_done, st_q == ST_PASS_END && conv_q, st_q == ST_EMIT)

endmodule

@@ bench/kmeans_2d_point_clustering_tb.sv @@
// self-checking bench for the 2-d k-means point clustering block
// drives point frames and register writes, predicts the centres, checks m_axis
// depends on kmc_pkg and kmeans_2d_point_clustering
`timescale 1ns / 1ps

module kmeans_2d_point_clustering_tb;
  import kmc_pkg::*;

  localparam int unsigned STORE_DEPTH = DEF_MAX_POINTS;
  localparam int unsigned CENTRES = DEF_MAX_CLUSTERS;

  typedef struct packed {
    logic          has_point;
    logic [XW-1:0] pos_x;
    logic [YW-1:0] pos_y;
    logic          frame_end;
  } pixel_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic [XW-1:0]        cx;
    logic [YW-1:0]        cy;
    logic                 conv;
    logic                 last;
  } centre_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  kmeans_2d_point_clustering dut (.*);

  pixel_t pixel_q[$];
  centre_t centre_q[$];
  int errors = 0;

  // predictor state
  int frame_x[$];
  int frame_y[$];
  int kept_x[CENTRES];
  int kept_y[CENTRES];
  int p_clusters = RST_NUM_CLUSTERS;
  int p_thresh = RST_THRESHOLD;
  int p_iters = RST_MAX_ITER;

  initial forever #5 clk_i = ~clk_i;

  function automatic int floor_sqrt(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  task automatic cluster_frame();
    int k, cap, passes, best, bd, d, nx, ny;
    bit conv, done;
    int cur_x[CENTRES];
    int cur_y[CENTRES];
    int sx[CENTRES];
    int sy[CENTRES];
    int cnt[CENTRES];
    centre_t r;
    k = (p_clusters == 0) ? 1 : (p_clusters > CENTRES ? CENTRES : p_clusters);
    cap = (p_iters == 0) ? 1 : p_iters;
    for (int c = 0; c < k; c++) begin
      cur_x[c] = kept_x[c];
      cur_y[c] = kept_y[c];
    end
    passes = 0;
    done = 0;
    conv = 0;
    while (!done) begin
      for (int c = 0; c < k; c++) begin
        sx[c] = 0; sy[c] = 0; cnt[c] = 1;
      end
      foreach (frame_x[p]) begin
        best = 0;
        bd = (frame_x[p] - cur_x[0]) ** 2 + (frame_y[p] - cur_y[0]) ** 2;
        for (int c = 1; c < k; c++) begin
          d = (frame_x[p] - cur_x[c]) ** 2 + (frame_y[p] - cur_y[c]) ** 2;
          if (d < bd) begin
            bd = d;
            best = c;
          end
        end
        cnt[best]++;
        sx[best] += frame_x[p];
        sy[best] += frame_y[p];
      end
      conv = 1;
      for (int c = 0; c < k; c++) begin
        nx = sx[c] / cnt[c];
        ny = sy[c] / cnt[c];
        kept_x[c] = cur_x[c];
        kept_y[c] = cur_y[c];
        if (floor_sqrt((nx - cur_x[c]) ** 2 + (ny - cur_y[c]) ** 2) > p_thresh) conv = 0;
        cur_x[c] = nx;
        cur_y[c] = ny;
      end
      passes++;
      if (conv || passes >= cap) done = 1;
    end
    frame_x.delete();
    frame_y.delete();
    for (int c = 0; c < k; c++) begin
      r.index = c[IDX_OUT_W-1:0];
      r.cx = cur_x[c][XW-1:0];
      r.cy = cur_y[c][YW-1:0];
      r.conv = conv;
      r.last = (c == k - 1);
      centre_q.push_back(r);
    end
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;
  bit in_taken = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      in_taken <= 1'b0;
      if (gap_left > 0 || pixel_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        pixel_t w;
        w = pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, w.pos_y, w.pos_x};
        s_axis_tuser <= w.has_point;
        s_axis_tlast <= w.frame_end;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver
  int hold_cnt = 0;
  bit long_hold = 0;
  int stall_kind = 0;
  int stall_tick = 0;
  always @(negedge clk_i) begin
    if (long_hold) begin
      long_hold = 0;
      hold_cnt = 600;
    end
    if (stall_tick == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_tick = $urandom_range(8, 40);
    end else begin
      stall_tick--;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (stall_kind == 0) begin
      m_axis_tready <= 1'b1;
    end else if (stall_kind == 1) begin
      m_axis_tready <= 1'($urandom_range(0, 1));
    end else begin
      m_axis_tready <= (stall_tick % 4) != 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken <= 1'b1;
        if (s_axis_tuser[0] && frame_x.size() < STORE_DEPTH) begin
          frame_x.push_back(int'(s_axis_tdata[XW-1:0]));
          frame_y.push_back(int'(s_axis_tdata[XW+YW-1:XW]));
        end
        if (s_axis_tlast) cluster_frame();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        centre_t got;
        got.index = m_axis_tuser[1:0];
        got.cx = m_axis_tdata[XW-1:0];
        got.cy = m_axis_tdata[XW+YW-1:XW];
        got.conv = m_axis_tuser[2];
        got.last = m_axis_tlast;
        if (centre_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected centre word, actual %p", $time, got);
        end else begin
          centre_t exp_c;
          exp_c = centre_q.pop_front();
          if (got !== exp_c || m_axis_tdata[TDATA_W-1:XW+YW] !== '0) begin
            errors++;
            $display("%0t: centre word differs, expected %p, actual %p", $time, exp_c, got);
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NUM_CLUSTERS: p_clusters = val & 7;
      CFG_THRESHOLD: p_thresh = val & 511;
      CFG_MAX_ITER: p_iters = val & 255;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_pixel(bit hp, int x, int y, bit fe);
    pixel_t w;
    w.has_point = hp;
    w.pos_x = x[XW-1:0];
    w.pos_y = y[YW-1:0];
    w.frame_end = fe;
    pixel_q.push_back(w);
  endtask

  task automatic random_frames(int n_items);
    int left, n;
    left = n_items;
    while (left > 0) begin
      n = $urandom_range(1, 14);
      for (int i = 0; i < n - 1; i++) begin
        if ($urandom_range(0, 9) == 0) push_pixel(0, $urandom_range(0, 319),
                                                  $urandom_range(0, 239), 0);
        else push_pixel(1, $urandom_range(0, 319), $urandom_range(0, 239), 0);
      end
      push_pixel($urandom_range(0, 3) != 0, $urandom_range(0, 319),
                 $urandom_range(0, 239), 1);
      left -= n;
    end
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || s_axis_tvalid || centre_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corners, idle word, point on frame end, empty frame
    push_pixel(1, 0, 0, 0);
    push_pixel(1, 319, 239, 0);
    push_pixel(0, 5, 5, 0);
    push_pixel(1, 319, 0, 0);
    push_pixel(1, 0, 239, 1);
    push_pixel(0, 0, 0, 1);
    push_pixel(1, 160, 120, 1);
    push_pixel(1, 10, 10, 0);
    push_pixel(0, 300, 200, 1);
    drain();

    write_reg(CFG_NUM_CLUSTERS, 4);
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_MAX_ITER, 255);
    random_frames(30);
    drain();

    write_reg(CFG_NUM_CLUSTERS, 1);
    write_reg(CFG_THRESHOLD, 511);
    write_reg(CFG_MAX_ITER, 1);
    random_frames(15);
    drain();

    // out-of-range count and zero pass cap, with a long receiver hold
    write_reg(CFG_NUM_CLUSTERS, 7);
    write_reg(CFG_THRESHOLD, 5);
    write_reg(CFG_MAX_ITER, 0);
    long_hold = 1;
    random_frames(25);
    drain();

    write_reg(CFG_NUM_CLUSTERS, 0);
    write_reg(CFG_THRESHOLD, 2);
    write_reg(CFG_MAX_ITER, 10);
    random_frames(15);
    drain();

    write_reg(CFG_NUM_CLUSTERS, 2);
    write_reg(CFG_THRESHOLD, 30);
    write_reg(CFG_MAX_ITER, 64);
    random_frames(25);
    drain();

    if (errors == 0) begin
      $display("kmeans_2d_point_clustering: match");
    end else begin
      $display("kmeans_2d_point_clustering: mismatch");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("kmeans_2d_point_clustering: mismatch");
    $finish;
  end

endmodule
